@@ rtl/core/pcc_pkg.sv @@
`default_nettype none

package pcc_pkg;

  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [31:0] TYPE_IHDR  = 32'h4948_4452;

  localparam int unsigned DIM_W = 31;
  localparam int unsigned LEN_W = 31;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_CRC,
    PH_HALT
  } pcc_phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CRC_ERR   = 2'd1,
    ST_BAD_SIG   = 2'd2,
    ST_TRUNCATED = 2'd3
  } pcc_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } pcc_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      chunk_type;
    logic [LEN_W-1:0] chunk_length;
    logic [31:0]      computed_crc;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } pcc_out_t;

  // Expected PNG signature byte at each position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'd137;
      3'd1:    b = 8'd80;
      3'd2:    b = 8'd78;
      3'd3:    b = 8'd71;
      3'd4:    b = 8'd13;
      3'd5:    b = 8'd10;
      3'd6:    b = 8'd26;
      3'd7:    b = 8'd10;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pcc_crc_step.sv @@
`default_nettype none

// One byte of reflected CRC-32, bit at a time over eight steps.
module pcc_crc_step (
  input  wire logic [31:0] crc_in,
  input  wire logic [7:0]  data_byte,
  output logic      [31:0] crc_out
);
  import pcc_pkg::*;

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_byte};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

@@ rtl/core/pcc_parse.sv @@
`default_nettype none

module pcc_parse (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire pcc_pkg::pcc_in_t  item,
  input  wire logic              verify_all,
  output logic                   res_vld,
  output pcc_pkg::pcc_out_t      res
);
  import pcc_pkg::*;

  pcc_phase_t        phase_r, phase_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [31:0]       type_r, type_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [3:0]        off_r, off_nxt;     // data byte offset, saturates at 8
  logic [31:0]       crc_r, crc_nxt;
  logic [31:0]       rcv_r, rcv_nxt;
  logic [DIM_W-1:0]  width_r, width_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;
  logic [31:0]       crc_stepped;

  pcc_crc_step u_crc (
    .crc_in    (crc_r),
    .data_byte (item.data_byte),
    .crc_out   (crc_stepped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      idx_r    <= '0;
      len_r    <= '0;
      type_r   <= '0;
      rem_r    <= '0;
      off_r    <= '0;
      crc_r    <= CRC_PRESET;
      rcv_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      len_r    <= len_nxt;
      type_r   <= type_nxt;
      rem_r    <= rem_nxt;
      off_r    <= off_nxt;
      crc_r    <= crc_nxt;
      rcv_r    <= rcv_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [31:0] computed;
    logic        ihdr;
    logic        bad;
    logic        boundary;

    b          = item.data_byte;
    computed   = ~crc_r;
    ihdr       = (type_r == TYPE_IHDR);
    bad        = 1'b0;
    boundary   = 1'b0;
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    type_nxt   = type_r;
    rem_nxt    = rem_r;
    off_nxt    = off_r;
    crc_nxt    = crc_r;
    rcv_nxt    = rcv_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    res_vld    = 1'b0;
    res        = '0;

    unique case (phase_r)
      PH_SIG: begin
        if (b != sig_byte(idx_r)) begin
          res_vld          = 1'b1;
          res.status       = ST_BAD_SIG;
          phase_nxt        = PH_HALT;
          idx_nxt          = '0;
        end else begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        len_nxt = {len_r[LEN_W-9:0], b};
        if (idx_r == 3'd3) begin
          idx_nxt   = '0;
          phase_nxt = PH_TYPE;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      PH_TYPE: begin
        type_nxt = {type_r[23:0], b};
        crc_nxt  = crc_stepped;
        if (idx_r == 3'd3) begin
          idx_nxt   = '0;
          rem_nxt   = len_r;
          off_nxt   = '0;
          phase_nxt = (len_r != '0) ? PH_DATA : PH_CRC;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      PH_DATA: begin
        if (ihdr) begin
          if (off_r < 4'd4) width_nxt = {width_r[DIM_W-9:0], b};
          else if (off_r < 4'd8) height_nxt = {height_r[DIM_W-9:0], b};
        end
        if (off_r != 4'd8) off_nxt = off_r + 4'd1;
        crc_nxt = crc_stepped;
        rem_nxt = rem_r - {{(LEN_W-1){1'b0}}, 1'b1};
        if (rem_r == {{(LEN_W-1){1'b0}}, 1'b1}) phase_nxt = PH_CRC;
      end
      PH_CRC: begin
        rcv_nxt = {rcv_r[23:0], b};
        if (idx_r == 3'd3) begin
          bad              = (ihdr || verify_all) && (computed != rcv_nxt);
          res_vld          = 1'b1;
          res.status       = bad ? ST_CRC_ERR : ST_OK;
          res.chunk_type   = type_r;
          res.chunk_length = len_r;
          res.computed_crc = computed;
          idx_nxt          = '0;
          if (bad && ihdr) begin
            phase_nxt = PH_HALT;
          end else begin
            phase_nxt = PH_LEN;
            crc_nxt   = CRC_PRESET;
            len_nxt   = '0;
            type_nxt  = '0;
            rcv_nxt   = '0;
            rem_nxt   = '0;
          end
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      PH_HALT: begin
      end
      default: begin
      end
    endcase

    res.image_width  = width_nxt;
    res.image_height = height_nxt;

    if (item.end_of_file) begin
      // ending on a chunk boundary or while halted is silent
      boundary = (phase_nxt == PH_LEN) && (idx_nxt == '0);
      if (!res_vld && phase_nxt != PH_HALT && !boundary) begin
        res_vld          = 1'b1;
        res.status       = ST_TRUNCATED;
        res.chunk_type   = type_nxt;
        res.chunk_length = len_nxt;
        res.computed_crc = ~crc_nxt;
      end
      phase_nxt  = PH_SIG;
      idx_nxt    = '0;
      len_nxt    = '0;
      type_nxt   = '0;
      rem_nxt    = '0;
      off_nxt    = '0;
      crc_nxt    = CRC_PRESET;
      rcv_nxt    = '0;
      width_nxt  = '0;
      height_nxt = '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/png_chunk_crc_checker_unit.sv @@
`default_nettype none

// PNG chunk checker. Takes one file byte per word, end_of_file on the last,
// and gives one word per finished chunk (type, length, CRC-32 over type and
// data, status, captured IHDR width/height), plus one word for a bad signature
// or a file cut off mid-chunk. A byte can be taken every cycle unless a word
// sits stalled in the result register. Each byte is registered in the input
// register and goes through one CRC byte step into the result register; a byte
// waits in the input register while an earlier word is stalled. A bad signature
// or a failing IHDR CRC makes the block drop bytes until end of file.
// cfg_data sets verify_all_chunks (1: check every chunk's CRC, 0: IHDR only);
// write it only while no file is in flight. cfg_ready is always high.
module png_chunk_crc_checker_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pcc_pkg::pcc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pcc_pkg::pcc_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data
);
  import pcc_pkg::*;

  logic     in_vld_r, in_vld_nxt;
  pcc_in_t  in_data_r;
  logic     out_vld_r, out_vld_nxt;
  pcc_out_t out_data_r;
  logic     verify_r;
  logic     fire;
  logic     res_vld;
  pcc_out_t res;

  assign fire      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !fire;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  pcc_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (in_data_r),
    .verify_all (verify_r),
    .res_vld    (res_vld),
    .res        (res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && !in_stall) in_vld_nxt = 1'b1;
    else if (fire) in_vld_nxt = 1'b0;

    out_vld_nxt = out_vld_r;
    if (fire && res_vld) out_vld_nxt = 1'b1;
    else if (out_vld_r && !out_stall) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      verify_r  <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) verify_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data_r <= in_data;
    if (fire && res_vld) out_data_r <= res;
  end

  // parser never advances into a full, stalled result register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !fire)
    else $error("parser advanced while result register blocked");

  // a held input word keeps its contents until the parser takes it
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !fire) |=> (in_vld_r && $stable(in_data_r)))
    else $error("input register lost a pending word");

  a_sig_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.status == ST_BAD_SIG) |->
      (out_data_r.chunk_type == '0 && out_data_r.chunk_length == '0 &&
       out_data_r.computed_crc == '0))
    else $error("bad signature word carries chunk fields");

endmodule

`default_nettype wire
